// ----- design/lsr_pkg.sv -----
`timescale 1ns / 1ps

package lsr_pkg;

  localparam int DEPTH = 64;
  localparam int WORD_W = 32;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = SLOT_W + 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [WORD_W-1:0] NEG_ONE = -32'sd1;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_DUMP    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    status_e                  status;
    logic                     last;
  } res_t;

  typedef struct packed {
    op_e                      op;
    logic signed [WORD_W-1:0] value;
  } q_item_t;

  // Moves a slot index by span steps around the ring; span is below DEPTH.
  function automatic logic [SLOT_W-1:0] step_dist(input logic [SLOT_W-1:0] slot,
                                                  input logic [CNT_W-1:0] span,
                                                  input logic fwd);
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] d;
    logic [SUM_W-1:0] r;
    s = SUM_W'(slot);
    d = SUM_W'(span);
    if (fwd) begin
      r = s + d;
      if (r >= SUM_W'(DEPTH)) begin
        r = r - SUM_W'(DEPTH);
      end
    end else if (s >= d) begin
      r = s - d;
    end else begin
      r = s + SUM_W'(DEPTH) - d;
    end
    return r[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] step_one(input logic [SLOT_W-1:0] slot,
                                                 input logic fwd);
    return step_dist(slot, CNT_W'(1), fwd);
  endfunction

endpackage

// ----- design/lifo_stack_with_reverse.sv -----
`timescale 1ns / 1ps

// Channel   Ports                     Transfer
// command   start_i, busy_o, cmd_i    start_i high while busy_o is low
// result    res_valid_o, res_o        res_valid_o high for a single cycle per result
//
// Push, pop and reverse pass through the command queue and then the registered result stage.
// Peek also passes through the registered RAM read before the registered result stage.
// Dump gives one result per cycle after the registered RAM read, top entry first.
// The command queue holds two items; busy_o rises only when it is full.
// Reset empties the stack and the queue; the result side never stalls.
module lifo_stack_with_reverse import lsr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  output res_t res_o
);

  logic    q_full, q_empty, q_wr, q_rd;
  q_item_t q_wr_item, q_rd_item;

  lsr_front u_front (
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .q_full_i(q_full),
    .busy_o  (busy_o),
    .q_wr_o  (q_wr),
    .q_item_o(q_wr_item)
  );

  lsr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_item_i(q_wr_item),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_item_o(q_rd_item),
    .empty_o  (q_empty)
  );

  lsr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_rd_item),
    .q_rd_o     (q_rd),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

// ----- design/lsr_ram.sv -----
`timescale 1ns / 1ps

module lsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/lsr_front.sv -----
`timescale 1ns / 1ps

module lsr_front import lsr_pkg::*; (
  input  logic    start_i,
  input  cmd_t    cmd_i,
  input  logic    q_full_i,
  output logic    busy_o,
  output logic    q_wr_o,
  output q_item_t q_item_o
);

  logic accept;

  assign busy_o = q_full_i;
  assign accept = start_i && !q_full_i;

  // Unknown operation codes are taken and dropped here.
  always_comb begin
    q_wr_o         = 1'b0;
    q_item_o.op    = OP_PUSH;
    q_item_o.value = cmd_i.push_value;
    case (cmd_i.operation)
      OP_PUSH, OP_POP, OP_PEEK, OP_REVERSE, OP_DUMP: begin
        q_wr_o      = accept;
        q_item_o.op = op_e'(cmd_i.operation);
      end
      default: begin
        q_wr_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/lsr_queue.sv -----
`timescale 1ns / 1ps

module lsr_queue import lsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  q_item_t wr_item_i,
  output logic    full_o,
  input  logic    rd_i,
  output q_item_t rd_item_o,
  output logic    empty_o
);

  q_item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, wptr_d;
  logic [QPTR_W-1:0]   rptr_q, rptr_d;
  logic [QCNT_W-1:0]   fill_q, fill_d;
  logic                do_wr, do_rd;

  assign full_o    = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (fill_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_item_o = slots_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_wr) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

// ----- design/lsr_back.sv -----
`timescale 1ns / 1ps

module lsr_back import lsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  q_item_t q_item_i,
  output logic    q_rd_o,
  output logic    res_valid_o,
  output res_t    res_o
);

  back_state_e       state_q, state_d;
  logic [SLOT_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              up_q, up_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              valid_q, valid_d;
  res_t              res_q, res_d;

  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              is_empty;

  assign is_empty = (count_q == '0);

  lsr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(q_item_i.value),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    count_d   = count_q;
    up_d      = up_q;
    slot_d    = slot_q;
    left_d    = left_q;
    valid_d   = 1'b0;
    res_d     = '{result_value: '0, status: ST_OK, last: 1'b1};
    q_rd_o    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = top_q;
    ram_raddr = top_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o = 1'b1;
          case (q_item_i.op)
            OP_PUSH: begin
              valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                res_d.status = ST_OVERFLOW;
              end else begin
                if (!is_empty) begin
                  top_d = step_one(top_q, up_q);
                end
                ram_we    = 1'b1;
                ram_waddr = top_d;
                count_d   = count_q + 1'b1;
              end
            end
            OP_POP: begin
              valid_d = 1'b1;
              if (is_empty) begin
                res_d.result_value = NEG_ONE;
                res_d.status       = ST_EMPTY;
              end else begin
                if (count_q > CNT_W'(1)) begin
                  top_d = step_one(top_q, !up_q);
                end
                count_d = count_q - 1'b1;
              end
            end
            OP_PEEK, OP_DUMP: begin
              if (is_empty) begin
                valid_d            = 1'b1;
                res_d.result_value = NEG_ONE;
                res_d.status       = ST_EMPTY;
              end else begin
                ram_re  = 1'b1;
                slot_d  = step_one(top_q, !up_q);
                left_d  = (q_item_i.op == OP_DUMP) ? count_q - 1'b1 : '0;
                state_d = BK_READ;
              end
            end
            OP_REVERSE: begin
              valid_d = 1'b1;
              if (count_q >= CNT_W'(2)) begin
                top_d = step_dist(top_q, count_q - 1'b1, !up_q);
                up_d  = !up_q;
              end
            end
            default: begin
              valid_d = 1'b0;
            end
          endcase
        end
      end
      BK_READ: begin
        valid_d            = 1'b1;
        res_d.result_value = ram_rdata;
        res_d.last         = (left_q == '0);
        if (left_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = slot_q;
          slot_d    = step_one(slot_q, !up_q);
          left_d    = left_q - 1'b1;
        end else begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      top_q   <= '0;
      count_q <= '0;
      up_q    <= 1'b1;
      slot_q  <= '0;
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      count_q <= count_d;
      up_q    <= up_d;
      slot_q  <= slot_d;
      left_q  <= left_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
